FILE: rtl/leg_contact_phase_estimator_macros.svh
// ============================================================================
// Leg contact phase estimator assertion macros
// Short forms for the concurrent checks used by the estimator modules.
// ============================================================================
`ifndef LEG_CONTACT_PHASE_ESTIMATOR_MACROS_SVH
`define LEG_CONTACT_PHASE_ESTIMATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCPE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LCPE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lcpe_pkg.sv
// ============================================================================
// Leg contact phase estimator package
// Shared constants, codes and controller/datapath interface types.
// ============================================================================
package lcpe_pkg;

    // Number of legs tracked and the width of one velocity component.
    localparam int LEG_COUNT = 4;
    localparam int VEL_BITS  = 16;
    localparam int LEG_IDX_W = (LEG_COUNT > 1) ? $clog2(LEG_COUNT) : 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_LEN0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEN1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEN2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEN3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TD_SQ = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIFT  = 3'd5;

    // Register reset values.
    localparam logic [15:0] RST_STANCE_LEN = 16'd100;
    localparam logic [31:0] RST_TD_LIMIT   = 32'd5898;
    localparam logic [14:0] RST_LIFT_LIMIT = 15'd179;

    // Item command codes.
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_UPDATE = 2'd1;
    localparam logic [1:0] CMD_REARM  = 2'd2;

    // Progress values in Q1.15.
    localparam logic [15:0] PROG_ZERO = 16'd0;
    localparam logic [15:0] PROG_HALF = 16'd16384;
    localparam logic [15:0] PROG_FULL = 16'd32768;

    // Sequencing lengths.
    localparam int SQ_STEPS  = 3;
    localparam int DIV_STEPS = 15;
    localparam int CNT_W     = 4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_UPD,
        S_DIV,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_in;
        logic       sq_en;
        logic [1:0] sq_idx;
        logic       sq_acc;
        logic       update;
        logic       div_step;
        logic       out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;
    } t_dp_stat;

endpackage

FILE: rtl/lcpe_dp.sv
// ============================================================================
// Leg contact phase estimator datapath
// Configuration registers, per-leg contact state, the squared velocity change
// accumulator, the serial progress divider and the result register.
// ============================================================================
module lcpe_dp import lcpe_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_dp_cmd                      i_ctl,
    output t_dp_stat                     o_stat,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic [1:0]                   i_cmd,
    input  logic [1:0]                   i_leg,
    input  logic signed [VEL_BITS-1:0]   i_foot_vx,
    input  logic signed [VEL_BITS-1:0]   i_foot_vy,
    input  logic signed [VEL_BITS-1:0]   i_foot_vz,
    input  logic signed [VEL_BITS-1:0]   i_lift_speed,
    output logic [1:0]                   o_leg_out,
    output logic [15:0]                  o_phase_progress,
    output logic                         o_in_stance,
    output logic                         o_awaiting_takeoff
);

    // Configuration registers.
    logic [15:0] r_stance_len [4];
    logic [31:0] r_td_limit;
    logic [14:0] r_lift_limit;

    // Latched transaction.
    logic [1:0]                 r_cmd;
    logic [1:0]                 r_leg;
    logic [VEL_BITS-1:0]        r_vel [3];
    logic signed [VEL_BITS-1:0] r_lift;

    // Per-leg contact state.
    logic [VEL_BITS-1:0]  r_last_vel [LEG_COUNT][3];
    logic [LEG_COUNT-1:0] r_pending;
    logic [LEG_COUNT-1:0] r_stance;
    logic [15:0]          r_count [LEG_COUNT];
    logic                 r_all_lifted;

    // Touchdown accumulator.
    logic [31:0] r_prod;
    logic [33:0] r_sum;
    logic        r_big;

    // Item result and divider.
    logic [15:0] r_prog;
    logic        r_need_div;
    logic        r_res_stance;
    logic        r_res_pend;
    logic [15:0] r_rem;
    logic [14:0] r_quo;

    // Output payload register.
    logic [1:0]  r_out_leg;
    logic [15:0] r_out_prog;
    logic        r_out_stance;
    logic        r_out_pend;

    logic [LEG_IDX_W-1:0] leg_idx;
    logic                 leg_ok;

    logic signed [VEL_BITS:0] sq_diff;
    logic [VEL_BITS:0]        sq_abs;
    logic [15:0]              sq_lo;
    logic [31:0]              sq_prod;
    logic                     sq_big;

    logic [15:0] dur;
    logic        all_now;
    logic        mode_stance;
    logic        touch;
    logic        lifted;
    logic        cur_pend;
    logic        cur_st;
    logic [15:0] cur_cnt;
    logic [16:0] cnt_inc;
    logic        n_pend;
    logic        n_st;
    logic [15:0] n_cnt;
    logic        n_all;
    logic [15:0] n_prog;
    logic        n_use_div;

    logic [16:0] div_sh;
    logic        div_ge;

    assign leg_idx = LEG_IDX_W'(r_leg);
    assign leg_ok  = (32'(r_leg) < 32'(LEG_COUNT));

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_stance_len[i] <= RST_STANCE_LEN;
            end
            r_td_limit   <= RST_TD_LIMIT;
            r_lift_limit <= RST_LIFT_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx) inside
                REG_LEN0, REG_LEN1, REG_LEN2, REG_LEN3: begin
                    r_stance_len[i_cfg_idx[1:0]] <= i_cfg_data[15:0];
                end
                REG_TD_SQ: begin
                    r_td_limit <= i_cfg_data[31:0];
                end
                REG_LIFT: begin
                    r_lift_limit <= i_cfg_data[14:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Squared change of one velocity component against the stored sample.
    always_comb begin
        sq_diff = {r_vel[i_ctl.sq_idx][VEL_BITS-1], r_vel[i_ctl.sq_idx]}
                - {r_last_vel[leg_idx][i_ctl.sq_idx][VEL_BITS-1],
                   r_last_vel[leg_idx][i_ctl.sq_idx]};
        sq_abs  = sq_diff[VEL_BITS] ? $unsigned(-sq_diff) : $unsigned(sq_diff);
        sq_big  = (34'(sq_abs) >= 34'd65536);
        sq_lo   = 16'(sq_abs);
        sq_prod = 32'(sq_lo) * 32'(sq_lo);
    end

    // Contact update for the latched leg.
    always_comb begin
        dur         = r_stance_len[r_leg];
        all_now     = ~|r_pending;
        mode_stance = (r_leg == 2'd0 && r_cmd == CMD_UPDATE) ? all_now : r_all_lifted;
        touch       = r_big || (r_sum > 34'(r_td_limit));
        lifted      = r_lift > $signed({1'b0, r_lift_limit});
        cur_pend    = r_pending[leg_idx];
        cur_st      = r_stance[leg_idx];
        cur_cnt     = r_count[leg_idx];
        cnt_inc     = 17'(cur_cnt) + 17'd1;

        n_pend    = cur_pend;
        n_st      = cur_st;
        n_cnt     = cur_cnt;
        n_all     = r_all_lifted;
        n_prog    = PROG_HALF;
        n_use_div = 1'b0;

        if (leg_ok) begin
            unique case (r_cmd)
                CMD_UPDATE: begin
                    if (r_leg == 2'd0) begin
                        n_all = all_now;
                    end
                    if (!mode_stance) begin
                        // Takeoff mode: a pending leg waits for its foot to lift.
                        if (cur_pend) begin
                            if (lifted) begin
                                n_prog = PROG_ZERO;
                                n_pend = 1'b0;
                                n_st   = 1'b0;
                            end
                        end else begin
                            n_prog = PROG_ZERO;
                        end
                    end else begin
                        // Stance mode: flight legs look for touchdown, stance legs count.
                        if (!cur_st) begin
                            if (touch) begin
                                n_st = 1'b1;
                            end
                        end else if (cnt_inc > 17'(dur)) begin
                            n_st  = 1'b0;
                            n_cnt = 16'd0;
                        end else begin
                            n_cnt = cnt_inc[15:0];
                        end
                        if (dur == 16'd0) begin
                            n_prog = PROG_ZERO;
                        end else if (n_cnt >= dur) begin
                            n_prog = PROG_FULL;
                        end else begin
                            n_use_div = 1'b1;
                        end
                    end
                end
                CMD_REARM: begin
                    n_pend = 1'b1;
                    n_all  = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // One restoring division step: remainder stays below the duration.
    always_comb begin
        div_sh = {r_rem, 1'b0};
        div_ge = (div_sh >= 17'(dur));
    end

    // Contact state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LEG_COUNT; l++) begin
                for (int c = 0; c < 3; c++) begin
                    r_last_vel[l][c] <= '0;
                end
                r_count[l] <= 16'd0;
            end
            r_pending    <= {LEG_COUNT{1'b1}};
            r_stance     <= '0;
            r_all_lifted <= 1'b0;
            r_need_div   <= 1'b0;
        end else if (i_ctl.update) begin
            if (leg_ok) begin
                r_pending[leg_idx] <= n_pend;
                r_stance[leg_idx]  <= n_st;
                r_count[leg_idx]   <= n_cnt;
                for (int c = 0; c < 3; c++) begin
                    r_last_vel[leg_idx][c] <= r_vel[c];
                end
                r_all_lifted <= n_all;
            end
            r_need_div <= n_use_div;
        end
    end

    // Transaction latch, accumulator, divider and output payload.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_cmd    <= i_cmd;
            r_leg    <= i_leg;
            r_vel[0] <= i_foot_vx;
            r_vel[1] <= i_foot_vy;
            r_vel[2] <= i_foot_vz;
            r_lift   <= i_lift_speed;
            r_sum    <= '0;
            r_big    <= 1'b0;
        end
        if (i_ctl.sq_en) begin
            r_prod <= sq_prod;
            if (sq_big) begin
                r_big <= 1'b1;
            end
        end
        if (i_ctl.sq_acc) begin
            r_sum <= r_sum + 34'(r_prod);
        end
        if (i_ctl.update) begin
            r_prog       <= n_prog;
            r_res_stance <= leg_ok ? n_st : 1'b0;
            r_res_pend   <= leg_ok ? n_pend : 1'b0;
            r_rem        <= n_cnt;
            r_quo        <= '0;
        end
        if (i_ctl.div_step) begin
            r_rem <= div_ge ? 16'(div_sh - 17'(dur)) : div_sh[15:0];
            r_quo <= {r_quo[13:0], div_ge};
        end
        if (i_ctl.out_load) begin
            r_out_leg    <= r_leg;
            r_out_prog   <= r_need_div ? {1'b0, r_quo} : r_prog;
            r_out_stance <= r_res_stance;
            r_out_pend   <= r_res_pend;
        end
    end

    assign o_stat.need_div    = r_need_div;
    assign o_leg_out          = r_out_leg;
    assign o_phase_progress   = r_out_prog;
    assign o_in_stance        = r_out_stance;
    assign o_awaiting_takeoff = r_out_pend;

endmodule

FILE: rtl/lcpe_ctrl.sv
// ============================================================================
// Leg contact phase estimator controller
// Sequences accumulation, update, division and result hand-over, and owns
// both handshakes.
// ============================================================================
`include "leg_contact_phase_estimator_macros.svh"

module lcpe_ctrl import lcpe_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_dp_cmd  o_ctl,
    input  t_dp_stat i_stat
);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_out_valid;

    // State and step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Result register occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_ctl      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.load_in = 1'b1;
                    n_cnt         = '0;
                    n_state       = S_SQ;
                end
            end
            S_SQ: begin
                // Products for components 0..2, each registered and summed in the next cycle.
                o_ctl.sq_en  = (r_cnt < CNT_W'(SQ_STEPS));
                o_ctl.sq_idx = r_cnt[1:0];
                o_ctl.sq_acc = (r_cnt != '0);
                if (r_cnt == CNT_W'(SQ_STEPS)) begin
                    n_cnt   = '0;
                    n_state = S_UPD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_UPD: begin
                o_ctl.update = 1'b1;
                n_state      = S_DIV;
            end
            S_DIV: begin
                if (!i_stat.need_div) begin
                    n_state = S_DONE;
                end else begin
                    o_ctl.div_step = 1'b1;
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        n_cnt   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    // Checks.
    `LCPE_ASSERT_IMP(a_load_free, i_clk, i_rst_n, o_ctl.out_load, !r_out_valid || i_out_ready, "result overwritten before it was taken")
    `LCPE_ASSERT_NXT(a_load_shows, i_clk, i_rst_n, o_ctl.out_load, o_out_valid && r_state == S_IDLE, "loaded result not presented")
    `LCPE_ASSERT_NXT(a_accept_seq, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_SQ && r_cnt == '0, "accepted transaction not sequenced")
    `LCPE_ASSERT_IMP(a_div_bound, i_clk, i_rst_n, r_state == S_DIV, r_cnt < CNT_W'(DIV_STEPS), "divider ran past its step count")

endmodule

FILE: rtl/leg_contact_phase_estimator.sv
// ============================================================================
// Leg contact phase estimator
// Tracks takeoff, touchdown and stance progress of each leg, one transaction
// per leg per control tick, with a controller and a separate datapath.
// ============================================================================
//
//  Channel   Signals                                    Direction
//  input     i_in_valid / o_in_ready, cmd, leg, vel     in
//  result    o_out_valid / i_out_ready, leg, progress   out
//  config    i_cfg_we, i_cfg_idx, i_cfg_data            in
//
//  A transaction runs from acceptance to a loaded result through the squared
//  velocity change (one shared 16x16 multiplier), the update, the divider
//  state, which passes straight on when no stance progress quotient is
//  needed or else runs the serial restoring divider, and the load of the
//  result register.
//  The next transaction is accepted in the cycle after the result is loaded,
//  even while that result still waits to be taken.
//  A stalled result holds the controller in its final state.
//  Reset is synchronous and active low; no clearing pass is needed.
//
module leg_contact_phase_estimator import lcpe_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_cmd,
    input  logic [1:0]                 i_leg,
    input  logic signed [VEL_BITS-1:0] i_foot_vx,
    input  logic signed [VEL_BITS-1:0] i_foot_vy,
    input  logic signed [VEL_BITS-1:0] i_foot_vz,
    input  logic signed [VEL_BITS-1:0] i_lift_speed,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_leg_out,
    output logic [15:0]                o_phase_progress,
    output logic                       o_in_stance,
    output logic                       o_awaiting_takeoff,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    t_dp_cmd  ctl;
    t_dp_stat stat;

    // Sequencer and handshakes.
    lcpe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ctl       (ctl),
        .i_stat      (stat)
    );

    // Registers, contact state and arithmetic.
    lcpe_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctl              (ctl),
        .o_stat             (stat),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_cmd              (i_cmd),
        .i_leg              (i_leg),
        .i_foot_vx          (i_foot_vx),
        .i_foot_vy          (i_foot_vy),
        .i_foot_vz          (i_foot_vz),
        .i_lift_speed       (i_lift_speed),
        .o_leg_out          (o_leg_out),
        .o_phase_progress   (o_phase_progress),
        .o_in_stance        (o_in_stance),
        .o_awaiting_takeoff (o_awaiting_takeoff)
    );

endmodule
